/* hdl/idpr_pkg.sv */
// Shared constants and types for the int8 dot product requantizer.
package idpr_pkg;

	localparam int ACC_WIDTH = 32;
	localparam int SCALE_WIDTH = 32;
	localparam int SCALE_FRAC_BITS = 24;
	localparam int PROD_WIDTH = ACC_WIDTH + SCALE_WIDTH;
	localparam int MAG_WIDTH = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MAG_WIDTH-1:0] RESULT_MAX = MAG_WIDTH'(127);
	localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (SCALE_FRAC_BITS - 1);

	typedef logic [ACC_WIDTH-1:0] acc_t;
	typedef logic [SCALE_WIDTH-1:0] scale_t;

	typedef struct packed {
		acc_t   sum;
		scale_t scale;
	} job_t;

endpackage

/* hdl/idpr_front.sv */
// Front end: multiply-accumulate of each beat, hands finished sums to the job queue.
module idpr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic signed [7:0]   activation,
	input  logic signed [7:0]   weight,
	input  logic signed [31:0]  bias,
	input  logic [31:0]         scale,
	input  logic                last,
	output logic                job_valid,
	output idpr_pkg::job_t      job
);
	import idpr_pkg::*;

	logic         accept;
	logic signed [15:0] prod;
	acc_t         acc_q;
	acc_t         acc_next;

	assign accept = push && !q_full;
	assign prod = activation * weight;
	assign acc_next = acc_q + ACC_WIDTH'(prod);

	assign job_valid = accept && last;
	assign job.sum = acc_next + ACC_WIDTH'(bias);
	assign job.scale = SCALE_WIDTH'(scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= last ? '0 : acc_next;
		end
	end

endmodule

/* hdl/idpr_queue.sv */
// Short job queue between the accumulator front end and the requantize back end.
module idpr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  idpr_pkg::job_t  wr_job,
	output logic            q_full,
	input  logic            rd_en,
	output logic            q_empty,
	output idpr_pkg::job_t  rd_job
);
	import idpr_pkg::*;

	job_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign q_full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/idpr_back.sv */
// Back end: magnitude, scale multiply, round and saturate, output register.
module idpr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  idpr_pkg::job_t     q_job,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [7:0]  result
);
	import idpr_pkg::*;

	logic                    advance;
	logic                    neg;
	acc_t                    mag;
	logic [PROD_WIDTH-1:0]   rounded;
	logic                    sat;
	logic [MAG_WIDTH-1:0]    mag_out;

	logic                    v_s1;
	logic                    neg_s1;
	acc_t                    mag_s1;
	scale_t                  scale_s1;
	logic                    v_s2;
	logic                    neg_s2;
	logic [PROD_WIDTH-1:0]   prod_s2;
	logic                    out_valid_q;
	logic signed [7:0]       result_q;

	assign advance = !out_valid_q || pop;
	assign q_pop = advance && !q_empty;

	assign neg = q_job.sum[ACC_WIDTH-1];
	assign mag = neg ? (~q_job.sum + 1'b1) : q_job.sum;

	assign rounded = prod_s2 + ROUND_HALF;
	assign sat = |rounded[PROD_WIDTH-1:SCALE_FRAC_BITS+MAG_WIDTH];
	assign mag_out = sat ? RESULT_MAX : rounded[SCALE_FRAC_BITS+MAG_WIDTH-1:SCALE_FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			neg_s1 <= neg;
			mag_s1 <= mag;
			scale_s1 <= q_job.scale;
			neg_s2 <= neg_s1;
			prod_s2 <= PROD_WIDTH'(mag_s1) * PROD_WIDTH'(scale_s1);
			result_q <= neg_s2 ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
		end
	end

	assign empty = !out_valid_q;
	assign result = result_q;

endmodule

/* hdl/int8_dot_product_requantize.sv */
// Top level of the int8 dot product requantizer.
// Accepts one activation/weight beat per clock while full is low and accumulates
// their product in a 32-bit wrapping accumulator; a beat with last set also adds
// the bias, closes the sum and clears the accumulator. Closed sums wait in a
// four-entry queue for the requantize pipeline, which takes one per clock while
// the result side is not stalled and presents the rounded, saturated int8 result
// through s1, s2 and the output register. full rises only when four closed sums
// are waiting behind a stalled result port, so a steady stream runs at one beat
// per clock; the 32x32 scale multiply has a pipeline stage of its own.
module int8_dot_product_requantize (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [7:0]  activation,
	input  logic signed [7:0]  weight,
	input  logic signed [31:0] bias,
	input  logic [31:0]        scale,
	input  logic               last,
	output logic               empty,
	input  logic               pop,
	output logic signed [7:0]  result
);
	import idpr_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_pop;
	logic job_valid;
	job_t job;
	job_t q_job;

	assign full = q_full;

	idpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (q_full),
		.activation (activation),
		.weight     (weight),
		.bias       (bias),
		.scale      (scale),
		.last       (last),
		.job_valid  (job_valid),
		.job        (job)
	);

	idpr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_job  (job),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_job  (q_job)
	);

	idpr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

/* hdl/idpr_checker.sv */
// Port-level checks for the int8 dot product requantizer and their bind.
module idpr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              last,
	input logic              pop,
	input logic              empty,
	input logic signed [7:0] result
);
	logic [3:0] pending_q;
	logic       in_last;
	logic       out_beat;

	assign in_last = push && !full && last;
	assign out_beat = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_last && !out_beat) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_beat && !in_last) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queue not empty after reset");

	a_no_minus_128: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result != 8'sh80)
		else $error("result outside symmetric range");

	a_result_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != '0)
		else $error("result without a closing last beat");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("stalled result changed");

endmodule

bind int8_dot_product_requantize idpr_checker u_chk (.*);
